// ===== rtl/g2enu_pkg.sv =====
// g2enu_pkg: constants, codes and small helpers of the geodetic to ENU converter
// no dependencies; used by rtl/geodetic_to_enu_converter.sv
package g2enu_pkg;

  // number format
  localparam int ANGLE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int ANGLE_DROP    = (ANGLE_BITS < 32) ? (32 - ANGLE_BITS) : 0;
  localparam logic [31:0] ANGLE_MASK = 32'hFFFF_FFFF << ANGLE_DROP;

  // field widths
  localparam int ANG_W  = 32;
  localparam int ALT_W  = 28;
  localparam int OUT_W  = 41;
  localparam int ORG_W  = 56;
  localparam int TRIG_W = 32;
  localparam int STEP_W = 5;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_FROM_FIRST_FIX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_FROM_NORTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_ORIGIN_LAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_ORIGIN_LON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_ORIGIN_ALT     = 3'd4;

  // arithmetic constants
  localparam logic [63:0] PI_Q32  = 64'd13493037705;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [63:0] A_MM    = 64'd6378137000;
  localparam logic [63:0] E2_Q40  = 64'd7360548640;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // series coefficients of 1/sqrt(1-t), Q40
  localparam logic [63:0] K_C5 = 64'd63 << 32;
  localparam logic [63:0] K_C4 = 64'd35 << 33;
  localparam logic [63:0] K_C3 = 64'd5 << 36;
  localparam logic [63:0] K_C2 = 64'd3 << 37;
  localparam logic [63:0] K_C1 = 64'd1 << 39;
  localparam logic [63:0] K_C0 = 64'd1 << 40;

  // reciprocals for exact floor division of values below 2^32, shift 40
  localparam int RCP_SH = 40;
  localparam logic [63:0] RCP_110 = ((64'd1 << RCP_SH) + 64'd109) / 64'd110;
  localparam logic [63:0] RCP_72  = ((64'd1 << RCP_SH) + 64'd71) / 64'd72;
  localparam logic [63:0] RCP_42  = ((64'd1 << RCP_SH) + 64'd41) / 64'd42;
  localparam logic [63:0] RCP_20  = ((64'd1 << RCP_SH) + 64'd19) / 64'd20;
  localparam logic [63:0] RCP_6   = ((64'd1 << RCP_SH) + 64'd5) / 64'd6;
  localparam logic [63:0] RCP_132 = ((64'd1 << RCP_SH) + 64'd131) / 64'd132;
  localparam logic [63:0] RCP_90  = ((64'd1 << RCP_SH) + 64'd89) / 64'd90;
  localparam logic [63:0] RCP_56  = ((64'd1 << RCP_SH) + 64'd55) / 64'd56;
  localparam logic [63:0] RCP_30  = ((64'd1 << RCP_SH) + 64'd29) / 64'd30;
  localparam logic [63:0] RCP_12  = ((64'd1 << RCP_SH) + 64'd11) / 64'd12;

  localparam logic signed [63:0] OUT_MAX = 64'sd1099511627775;
  localparam logic signed [63:0] OUT_MIN = -64'sd1099511627776;

  // reciprocal used by a division step of the sine/cosine series
  function automatic logic [63:0] rcp_sel(input logic [STEP_W-1:0] step);
    logic [63:0] r;
    case (step)
      5'd2:    r = RCP_110;
      5'd4:    r = RCP_72;
      5'd6:    r = RCP_42;
      5'd8:    r = RCP_20;
      5'd10:   r = RCP_6;
      5'd12:   r = RCP_132;
      5'd14:   r = RCP_90;
      5'd16:   r = RCP_56;
      5'd18:   r = RCP_30;
      5'd20:   r = RCP_12;
      default: r = RCP_6;
    endcase
    return r;
  endfunction

  // Horner constant added after a step of the radius series
  function automatic logic [63:0] k_coef(input logic [STEP_W-1:0] step);
    logic [63:0] c;
    case (step)
      5'd2:    c = K_C4;
      5'd3:    c = K_C3;
      5'd4:    c = K_C2;
      5'd5:    c = K_C1;
      5'd6:    c = K_C0;
      default: c = K_C0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/geodetic_to_enu_converter.sv =====
// geodetic_to_enu_converter: WGS84 fix to ECEF to local east/north/up, one fix at a time
// depends on rtl/g2enu_pkg.sv
//
// One fix in, one result out. All products go through a single shared 32x32
// multiplier that builds each 64x64 product from four partial products, then
// rounds it and writes it back. A fix needs 65 products (sine/cosine of
// latitude and longitude, the ECEF point, the ENU rotation). The first fix
// after reset also latches the origin, which costs another 57 products. A new
// fix is taken once the previous one has left the arithmetic, even while its
// result still waits at the output.
module geodetic_to_enu_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [g2enu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [g2enu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // fix input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [g2enu_pkg::ANG_W-1:0]   fix_lat_i,
  input  logic signed [g2enu_pkg::ANG_W-1:0]   fix_lon_i,
  input  logic signed [g2enu_pkg::ALT_W-1:0]   fix_alt_i,
  input  logic signed [g2enu_pkg::ANG_W-1:0]   fix_heading_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [g2enu_pkg::OUT_W-1:0]   east_o,
  output logic signed [g2enu_pkg::OUT_W-1:0]   north_o,
  output logic signed [g2enu_pkg::OUT_W-1:0]   up_o,
  output logic signed [g2enu_pkg::ANG_W-1:0]   yaw_enu_o,
  output logic                                 origin_latched_now_o
);
  import g2enu_pkg::*;

  // top states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // phases of the program
  localparam logic [1:0] PH_LAT  = 2'd0;
  localparam logic [1:0] PH_LON  = 2'd1;
  localparam logic [1:0] PH_ECEF = 2'd2;
  localparam logic [1:0] PH_ENU  = 2'd3;

  // cycles of one product
  localparam logic [2:0] MC_LOAD  = 3'd0;
  localparam logic [2:0] MC_ROUND = 3'd5;
  localparam logic [2:0] MC_LAST  = 3'd6;

  localparam logic [STEP_W-1:0] LAST_SINCOS = 5'd21;
  localparam logic [STEP_W-1:0] LAST_ECEF   = 5'd12;
  localparam logic [STEP_W-1:0] LAST_ENU    = 5'd7;

  localparam logic [5:0] SH_LEN = 6'(RCP_SH - FRACTION_BITS);

  // control
  logic [1:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [2:0]        mc_q, mc_d;
  logic              pass_org_q, pass_org_d;
  logic              origin_valid_q;
  logic              out_valid_q, out_valid_d;

  // configuration registers
  logic              first_fix_q;
  logic              hdg_north_q;
  logic [ANG_W-1:0]  preset_lat_q;
  logic [ANG_W-1:0]  preset_lon_q;
  logic [ALT_W-1:0]  preset_alt_q;

  // latched fix
  logic [ANG_W-1:0]  fix_lat_q, fix_lon_q;
  logic [ALT_W-1:0]  fix_alt_q;
  logic [ANG_W-1:0]  yaw_q;
  logic              latched_q;

  // working registers
  logic [31:0]        x_q, x2_q;
  logic [32:0]        t_q, sv_q;
  logic signed [63:0] m_q, p_q, n_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [63:0] e_q, nr_q, u_q;
  logic signed [TRIG_W-1:0] wlt_s_q, wlt_c_q, wln_s_q, wln_c_q;
  logic signed [TRIG_W-1:0] olt_s_q, olt_c_q, oln_s_q, oln_c_q;
  logic signed [ORG_W-1:0]  ox_q, oy_q, oz_q;

  // shared multiplier
  logic [63:0]        a_mag_q, b_mag_q;
  logic               neg_q;
  logic [5:0]         sh_q;
  logic               rnd_q;
  logic [127:0]       acc_q;
  logic signed [63:0] res_q;

  logic in_acc, out_acc, out_load, op_done;
  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign op_done  = (state_q == ST_RUN) && (mc_q == MC_LAST);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // angle of the current pass and its octant reduction
  logic              use_preset;
  logic [ANG_W-1:0]  lat_src, lon_src, ang_m;
  logic [ALT_W-1:0]  alt_src;
  logic [1:0]        quad;
  logic [29:0]       r_raw;
  logic              swap;
  logic [30:0]       r_oct;
  logic signed [63:0] h_val;

  assign use_preset = pass_org_q && !first_fix_q;
  assign lat_src = use_preset ? preset_lat_q : fix_lat_q;
  assign lon_src = use_preset ? preset_lon_q : fix_lon_q;
  assign alt_src = use_preset ? preset_alt_q : fix_alt_q;
  assign ang_m   = ((phase_q == PH_LON) ? lon_src : lat_src) & ANGLE_MASK;
  assign quad    = ang_m[31:30];
  assign r_raw   = ang_m[29:0];
  assign swap    = (r_raw > 30'h2000_0000);
  assign r_oct   = swap ? (31'h4000_0000 - {1'b0, r_raw}) : {1'b0, r_raw};
  assign h_val   = {{(64-ALT_W-FRACTION_BITS){alt_src[ALT_W-1]}}, alt_src,
                    {FRACTION_BITS{1'b0}}};

  // ECEF differences to the origin
  logic signed [63:0] dx, dy, dz;
  assign dx = px_q - {{(64-ORG_W){ox_q[ORG_W-1]}}, ox_q};
  assign dy = py_q - {{(64-ORG_W){oy_q[ORG_W-1]}}, oy_q};
  assign dz = pz_q - {{(64-ORG_W){oz_q[ORG_W-1]}}, oz_q};

  function automatic logic signed [63:0] sx(input logic signed [TRIG_W-1:0] v);
    return {{(64-TRIG_W){v[TRIG_W-1]}}, v};
  endfunction

  // operand selection of the current step
  logic signed [63:0] op_a, op_b;
  logic [5:0]         op_sh;
  logic               op_rnd;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sh  = 6'd30;
    op_rnd = 1'b1;
    case (phase_q)
      PH_LAT, PH_LON: begin
        if (step_q == 5'd0) begin
          op_a  = {33'd0, r_oct};
          op_b  = PI_Q32;
          op_sh = 6'd31;
        end else if (step_q == 5'd1) begin
          op_a  = {32'd0, x_q};
          op_b  = {32'd0, x_q};
          op_sh = 6'd32;
        end else if (step_q == 5'd11) begin
          op_a  = {32'd0, x_q};
          op_b  = {31'd0, t_q};
          op_sh = 6'd32;
        end else if (!step_q[0]) begin
          op_a   = (step_q == 5'd2 || step_q == 5'd12) ? {32'd0, x2_q} : m_q;
          op_b   = rcp_sel(step_q);
          op_sh  = 6'(RCP_SH);
          op_rnd = 1'b0;
        end else begin
          op_a  = {32'd0, x2_q};
          op_b  = {31'd0, t_q};
          op_sh = 6'd32;
        end
      end
      PH_ECEF: begin
        case (step_q)
          5'd0: begin
            op_a   = sx(wlt_s_q);
            op_b   = sx(wlt_s_q);
            op_sh  = 6'd0;
            op_rnd = 1'b0;
          end
          5'd1: begin
            op_a  = E2_Q40;
            op_b  = m_q;
            op_sh = 6'd60;
          end
          5'd2: begin
            op_a  = {31'd0, t_q};
            op_b  = K_C5;
            op_sh = 6'(RCP_SH);
          end
          5'd3, 5'd4, 5'd5, 5'd6: begin
            op_a  = {31'd0, t_q};
            op_b  = p_q;
            op_sh = 6'(RCP_SH);
          end
          5'd7: begin
            op_a  = A_MM;
            op_b  = p_q;
            op_sh = SH_LEN;
          end
          5'd8: begin
            op_a = n_q + h_val;
            op_b = sx(wlt_c_q);
          end
          5'd9: begin
            op_a = m_q;
            op_b = sx(wln_c_q);
          end
          5'd10: begin
            op_a = m_q;
            op_b = sx(wln_s_q);
          end
          5'd11: begin
            op_a  = n_q;
            op_b  = E2_Q40;
            op_sh = 6'(RCP_SH);
          end
          default: begin
            op_a = n_q - m_q + h_val;
            op_b = sx(wlt_s_q);
          end
        endcase
      end
      default: begin
        case (step_q)
          5'd0: begin op_a = dy;  op_b = sx(oln_c_q); end
          5'd1: begin op_a = dx;  op_b = sx(oln_s_q); end
          5'd2: begin op_a = dx;  op_b = sx(oln_c_q); end
          5'd3: begin op_a = dy;  op_b = sx(oln_s_q); end
          5'd4: begin op_a = dz;  op_b = sx(olt_c_q); end
          5'd5: begin op_a = p_q; op_b = sx(olt_s_q); end
          5'd6: begin op_a = p_q; op_b = sx(olt_c_q); end
          default: begin op_a = dz; op_b = sx(olt_s_q); end
        endcase
      end
    endcase
  end

  // partial product of the shared multiplier
  logic [1:0]   pidx;
  logic [63:0]  pp;
  logic [127:0] pp_ext, rnd_term;
  logic [127:0] res_wide;
  logic [63:0]  res_mag;

  assign pidx = 2'(mc_q - 3'd1);
  assign pp   = (pidx[1] ? a_mag_q[63:32] : a_mag_q[31:0])
              * (pidx[0] ? b_mag_q[63:32] : b_mag_q[31:0]);

  always_comb begin
    case (pidx)
      2'd0:    pp_ext = {64'd0, pp};
      2'd3:    pp_ext = {pp, 64'd0};
      default: pp_ext = {32'd0, pp, 32'd0};
    endcase
  end

  assign rnd_term = rnd_q ? (128'd1 << (sh_q - 6'd1)) : 128'd0;
  assign res_wide = (acc_q + rnd_term) >> sh_q;
  assign res_mag  = res_wide[63:0];

  // end of the sine/cosine series: fold back by octant and quadrant
  logic [32:0] cv;
  logic [33:0] s_sum, c_sum;
  logic signed [TRIG_W-1:0] s_o, c_o, s_sw, c_sw, sc_s, sc_c;

  assign cv    = ONE_Q32 - {1'b0, res_q[32:1]};
  assign s_sum = {1'b0, sv_q} + 34'd2;
  assign c_sum = {1'b0, cv} + 34'd2;
  assign s_o   = s_sum[33:2];
  assign c_o   = c_sum[33:2];
  assign s_sw  = swap ? c_o : s_o;
  assign c_sw  = swap ? s_o : c_o;

  always_comb begin
    case (quad)
      2'd0:    begin sc_s = s_sw;  sc_c = c_sw;  end
      2'd1:    begin sc_s = c_sw;  sc_c = -s_sw; end
      2'd2:    begin sc_s = -s_sw; sc_c = -c_sw; end
      default: begin sc_s = -c_sw; sc_c = s_sw;  end
    endcase
  end

  // rounding to millimetres with saturation
  function automatic logic signed [OUT_W-1:0] to_mm(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    return r[OUT_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] phase_last(input logic [1:0] ph);
    logic [STEP_W-1:0] l;
    case (ph)
      PH_ECEF: l = LAST_ECEF;
      PH_ENU:  l = LAST_ENU;
      default: l = LAST_SINCOS;
    endcase
    return l;
  endfunction

  // sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    step_d     = step_q;
    mc_d       = mc_q;
    pass_org_d = pass_org_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d    = ST_RUN;
          phase_d    = PH_LAT;
          step_d     = '0;
          mc_d       = MC_LOAD;
          pass_org_d = !origin_valid_q;
        end
      end
      ST_RUN: begin
        if (mc_q != MC_LAST) begin
          mc_d = mc_q + 3'd1;
        end else begin
          mc_d = MC_LOAD;
          if (step_q != phase_last(phase_q)) begin
            step_d = step_q + 5'd1;
          end else begin
            step_d = '0;
            case (phase_q)
              PH_LAT:  phase_d = PH_LON;
              PH_LON:  phase_d = PH_ECEF;
              PH_ECEF: begin
                if (pass_org_q) begin
                  pass_org_d = 1'b0;
                  phase_d    = PH_LAT;
                end else begin
                  phase_d = PH_ENU;
                end
              end
              default: state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_acc);

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      phase_q        <= PH_LAT;
      step_q         <= '0;
      mc_q           <= MC_LOAD;
      pass_org_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      origin_valid_q <= 1'b0;
      first_fix_q    <= 1'b1;
      hdg_north_q    <= 1'b1;
      preset_lat_q   <= '0;
      preset_lon_q   <= '0;
      preset_alt_q   <= '0;
      olt_s_q        <= '0;
      olt_c_q        <= '0;
      oln_s_q        <= '0;
      oln_c_q        <= '0;
      ox_q           <= '0;
      oy_q           <= '0;
      oz_q           <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      mc_q        <= mc_d;
      pass_org_q  <= pass_org_d;
      out_valid_q <= out_valid_d;
      // configuration write
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ORIGIN_FROM_FIRST_FIX: first_fix_q  <= cfg_data_i[0];
          CFG_HEADING_FROM_NORTH:    hdg_north_q  <= cfg_data_i[0];
          CFG_PRESET_ORIGIN_LAT:     preset_lat_q <= cfg_data_i;
          CFG_PRESET_ORIGIN_LON:     preset_lon_q <= cfg_data_i;
          CFG_PRESET_ORIGIN_ALT:     preset_alt_q <= cfg_data_i[ALT_W-1:0];
          default: ;
        endcase
      end
      // origin commit at the end of the latch pass
      if (op_done && phase_q == PH_ECEF && step_q == LAST_ECEF && pass_org_q) begin
        origin_valid_q <= 1'b1;
        ox_q    <= px_q[ORG_W-1:0];
        oy_q    <= py_q[ORG_W-1:0];
        oz_q    <= res_q[ORG_W-1:0];
        olt_s_q <= wlt_s_q;
        olt_c_q <= wlt_c_q;
        oln_s_q <= wln_s_q;
        oln_c_q <= wln_c_q;
      end
    end
  end

  // fix capture, multiplier and write-back
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fix_lat_q <= fix_lat_i;
      fix_lon_q <= fix_lon_i;
      fix_alt_q <= fix_alt_i;
      yaw_q     <= fix_heading_i - (hdg_north_q ? QUARTER_TURN : 32'd0);
      latched_q <= !origin_valid_q;
    end
    // multiplier pipeline
    if (state_q == ST_RUN) begin
      if (mc_q == MC_LOAD) begin
        a_mag_q <= op_a[63] ? 64'(-op_a) : op_a;
        b_mag_q <= op_b[63] ? 64'(-op_b) : op_b;
        neg_q   <= op_a[63] ^ op_b[63];
        sh_q    <= op_sh;
        rnd_q   <= op_rnd;
      end else if (mc_q == 3'd1) begin
        acc_q <= pp_ext;
      end else if (mc_q < MC_ROUND) begin
        acc_q <= acc_q + pp_ext;
      end else if (mc_q == MC_ROUND) begin
        res_q <= neg_q ? -$signed(res_mag) : $signed(res_mag);
      end
    end
    // write-back of the finished product
    if (op_done) begin
      case (phase_q)
        PH_LAT, PH_LON: begin
          if (step_q == 5'd0) begin
            x_q <= res_q[31:0];
          end else if (step_q == 5'd1) begin
            x2_q <= res_q[31:0];
          end else if (step_q == 5'd11) begin
            sv_q <= res_q[32:0];
          end else if (step_q == LAST_SINCOS) begin
            if (phase_q == PH_LAT) begin
              wlt_s_q <= sc_s;
              wlt_c_q <= sc_c;
            end else begin
              wln_s_q <= sc_s;
              wln_c_q <= sc_c;
            end
          end else if (!step_q[0]) begin
            t_q <= ONE_Q32 - res_q[32:0];
          end else begin
            m_q <= res_q;
          end
        end
        PH_ECEF: begin
          case (step_q)
            5'd0, 5'd8, 5'd11: m_q <= res_q;
            5'd1:  t_q  <= res_q[32:0];
            5'd7:  n_q  <= res_q;
            5'd9:  px_q <= res_q;
            5'd10: py_q <= res_q;
            5'd12: pz_q <= res_q;
            default: p_q <= k_coef(step_q) + res_q;
          endcase
        end
        default: begin
          case (step_q)
            5'd1: e_q  <= m_q - res_q;
            5'd3: p_q  <= m_q + res_q;
            5'd5: nr_q <= m_q - res_q;
            5'd7: u_q  <= m_q + res_q;
            default: m_q <= res_q;
          endcase
        end
      endcase
    end
    // output register
    if (out_load) begin
      east_o               <= to_mm(e_q);
      north_o              <= to_mm(nr_q);
      up_o                 <= to_mm(u_q);
      yaw_enu_o            <= yaw_q;
      origin_latched_now_o <= latched_q;
    end
  end

`ifndef SYNTHESIS
  // an accepted transaction starts the program at its first product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_RUN && mc_q == MC_LOAD
      && phase_q == PH_LAT && step_q == '0)
    else $error("program did not start after accepted transaction");

  // a result appears only from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the finish state");

  // product cycle counter stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> mc_q <= MC_LAST)
    else $error("product cycle counter out of range");

  // ENU rotation and results need a latched origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && phase_q == PH_ENU) || out_valid_o |-> origin_valid_q)
    else $error("ENU work without a latched origin");

  // the latch pass never runs once the origin is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && pass_org_q |-> !origin_valid_q)
    else $error("origin latch pass with origin already valid");
`endif

endmodule

// ===== tb/sv/geodetic_to_enu_converter_tb.sv =====
// geodetic_to_enu_converter_tb: self-checking testbench of the geodetic to ENU converter
// depends on rtl/g2enu_pkg.sv and rtl/geodetic_to_enu_converter.sv
// fixes are predicted by a fixed-point model of WGS84 -> ECEF -> ENU and checked in order
`timescale 1ns / 100ps

module geodetic_to_enu_converter_tb;
  import g2enu_pkg::*;

  typedef struct packed {
    logic [ANG_W-1:0] lat;
    logic [ANG_W-1:0] lon;
    logic [ALT_W-1:0] alt;
    logic [ANG_W-1:0] heading;
  } fix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] east;
    logic signed [OUT_W-1:0] north;
    logic signed [OUT_W-1:0] up;
    logic [ANG_W-1:0]        yaw;
    logic                    latched;
  } enu_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, origin_latched_now_o;
  logic signed [ANG_W-1:0] fix_lat_i, fix_lon_i, fix_heading_i, yaw_enu_o;
  logic signed [ALT_W-1:0] fix_alt_i;
  logic signed [OUT_W-1:0] east_o, north_o, up_o;

  geodetic_to_enu_converter u_top (.*);

  // predictor configuration and origin state
  logic        latch_from_fix, yaw_from_north;
  logic [31:0] preset_lat, preset_lon;
  logic [27:0] preset_alt;
  logic        origin_set;
  logic signed [63:0] org_xyz [3];
  logic signed [63:0] org_lat_sc [2];
  logic signed [63:0] org_lon_sc [2];
  fix_t        origin_fix;

  enu_t expected_enu [$];
  int   mismatches, fixes_sent, results_checked;
  bit   no_idle, hold_req;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // fixed-point arithmetic
  function automatic logic [63:0] umul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] smul_shr(logic signed [63:0] a,
                                                  logic signed [63:0] b, int s);
    logic [63:0] m;
    m = umul_shr(mag(a), mag(b), s);
    return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b + 64'h8000_0000;
    return p >> 32;
  endfunction

  // sine and cosine in Q30 by octant reduction and Taylor series
  task automatic sin_cos(input logic [31:0] raw, output logic signed [63:0] so,
                         output logic signed [63:0] co);
    logic [31:0] ang;
    logic [1:0] quad;
    logic [63:0] r, x, x2, t, sv, cv, one;
    logic signed [63:0] s, c, tmp;
    logic swap;
    one = 64'(ONE_Q32);
    ang = raw & ANGLE_MASK;
    quad = ang[31:30];
    r = {34'd0, ang[29:0]};
    swap = r > 64'h2000_0000;
    if (swap) r = 64'h4000_0000 - r;
    x = (r * PI_Q32 + 64'h4000_0000) >> 31;
    x2 = (x * x + 64'h8000_0000) >> 32;
    t = one - x2 / 110;
    t = one - mul_q32(x2, t) / 72;
    t = one - mul_q32(x2, t) / 42;
    t = one - mul_q32(x2, t) / 20;
    t = one - mul_q32(x2, t) / 6;
    sv = mul_q32(x, t);
    t = one - x2 / 132;
    t = one - mul_q32(x2, t) / 90;
    t = one - mul_q32(x2, t) / 56;
    t = one - mul_q32(x2, t) / 30;
    t = one - mul_q32(x2, t) / 12;
    cv = one - mul_q32(x2, t) / 2;
    s = $signed((sv + 2) >> 2);
    c = $signed((cv + 2) >> 2);
    if (swap) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      2'd0: begin so = s;  co = c;  end
      2'd1: begin so = c;  co = -s; end
      2'd2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
  endtask

  // geodetic to ECEF, millimetres with fraction bits
  task automatic geo_to_ecef(input logic [31:0] lat, input logic [31:0] lon,
                             input logic [27:0] alt, output logic signed [63:0] xyz [3],
                             output logic signed [63:0] lt [2],
                             output logic signed [63:0] ln [2]);
    logic [63:0] t, p, k, ss, n, ne2;
    logic signed [27:0] a28;
    logic signed [63:0] h, nh, pc;
    sin_cos(lat, lt[0], lt[1]);
    sin_cos(lon, ln[0], ln[1]);
    ss = mag(lt[0]) * mag(lt[0]);
    t = umul_shr(E2_Q40, ss, 60);
    p = K_C5;
    p = K_C4 + umul_shr(t, p, 40);
    p = K_C3 + umul_shr(t, p, 40);
    p = K_C2 + umul_shr(t, p, 40);
    p = K_C1 + umul_shr(t, p, 40);
    k = K_C0 + umul_shr(t, p, 40);
    n = umul_shr(A_MM, k, 40 - FRACTION_BITS);
    a28 = alt;
    h = 64'(a28) <<< FRACTION_BITS;
    nh = $signed(n) + h;
    pc = smul_shr(nh, lt[1], 30);
    xyz[0] = smul_shr(pc, ln[1], 30);
    xyz[1] = smul_shr(pc, ln[0], 30);
    ne2 = umul_shr(n, E2_Q40, 40);
    xyz[2] = smul_shr($signed(n) - $signed(ne2) + h, lt[0], 30);
  endtask

  function automatic logic signed [OUT_W-1:0] round_sat_mm(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  task automatic predict_enu(input fix_t f, output enu_t res);
    logic signed [63:0] p [3];
    logic signed [63:0] lt [2];
    logic signed [63:0] ln [2];
    logic signed [63:0] dx, dy, dz, e, q, n, u;
    res.latched = 1'b0;
    if (!origin_set) begin
      if (latch_from_fix) geo_to_ecef(f.lat, f.lon, f.alt, org_xyz, org_lat_sc, org_lon_sc);
      else geo_to_ecef(preset_lat, preset_lon, preset_alt, org_xyz, org_lat_sc, org_lon_sc);
      origin_set = 1'b1;
      res.latched = 1'b1;
    end
    geo_to_ecef(f.lat, f.lon, f.alt, p, lt, ln);
    dx = p[0] - org_xyz[0];
    dy = p[1] - org_xyz[1];
    dz = p[2] - org_xyz[2];
    e = smul_shr(dy, org_lon_sc[1], 30) - smul_shr(dx, org_lon_sc[0], 30);
    q = smul_shr(dx, org_lon_sc[1], 30) + smul_shr(dy, org_lon_sc[0], 30);
    n = smul_shr(dz, org_lat_sc[1], 30) - smul_shr(q, org_lat_sc[0], 30);
    u = smul_shr(q, org_lat_sc[1], 30) + smul_shr(dz, org_lat_sc[0], 30);
    res.east = round_sat_mm(e);
    res.north = round_sat_mm(n);
    res.up = round_sat_mm(u);
    res.yaw = f.heading - (yaw_from_north ? QUARTER_TURN : 32'd0);
  endtask

  // register write, only while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_FROM_FIRST_FIX: latch_from_fix = data[0];
      CFG_HEADING_FROM_NORTH:    yaw_from_north = data[0];
      CFG_PRESET_ORIGIN_LAT:     preset_lat = data;
      CFG_PRESET_ORIGIN_LON:     preset_lon = data;
      CFG_PRESET_ORIGIN_ALT:     preset_alt = data[27:0];
      default: ;
    endcase
  endtask

  // send one fix; valid stays high for the next one unless a gap is drawn
  task automatic send_fix(input fix_t f);
    enu_t res;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    fix_lat_i <= f.lat;
    fix_lon_i <= f.lon;
    fix_alt_i <= f.alt;
    fix_heading_i <= f.heading;
    do @(posedge clk_i); while (in_stall_o);
    predict_enu(f, res);
    expected_enu = {expected_enu, res};
    fixes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_enu.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic fix_t make_fix(logic [31:0] lat, logic [31:0] lon, int alt,
                                    logic [31:0] hdg);
    fix_t f;
    f.lat = lat;
    f.lon = lon;
    f.alt = alt[27:0];
    f.heading = hdg;
    return f;
  endfunction

  function automatic fix_t random_fix();
    fix_t f;
    int kind, alt;
    kind = $urandom_range(0, 19);
    alt = int'($urandom_range(110000000)) - 10000000;
    f = make_fix($urandom_range(32'h8000_0000) - 32'h4000_0000, $urandom, alt, $urandom);
    if (kind < 4) begin
      // close to the origin
      f.lat = origin_fix.lat + $urandom_range(200000) - 100000;
      f.lon = origin_fix.lon + $urandom_range(200000) - 100000;
      f.alt = 28'(origin_fix.alt + $urandom_range(200000) - 100000);
    end else if (kind < 7) begin
      f.lat = $urandom;
      f.alt = 28'($urandom);
    end
    return f;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    enu_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_enu.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result east %0d", east_o);
      end else begin
        want = expected_enu.pop_front();
        results_checked++;
        if (east_o !== want.east || north_o !== want.north || up_o !== want.up ||
            yaw_enu_o !== want.yaw || origin_latched_now_o !== want.latched) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp e %0d n %0d u %0d yaw %h l %b, got e %0d n %0d u %0d yaw %h l %b",
                     results_checked, want.east, want.north, want.up, want.yaw, want.latched,
                     east_o, north_o, up_o, yaw_enu_o, origin_latched_now_o);
        end
      end
    end
  end

  // receiver stalls: random bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // first fix latches the preset origin, then the field extremes
  task automatic test_preset_origin();
    write_reg(CFG_ORIGIN_FROM_FIRST_FIX, 32'd0);
    write_reg(CFG_HEADING_FROM_NORTH, 32'd1);
    write_reg(CFG_PRESET_ORIGIN_LAT, 32'h2000_0000);
    write_reg(CFG_PRESET_ORIGIN_LON, 32'h1555_5555);
    write_reg(CFG_PRESET_ORIGIN_ALT, 32'd250000);
    origin_fix = make_fix(32'h2000_0000, 32'h1555_5555, 250000, 0);
    send_fix(make_fix(32'h2000_1000, 32'h1555_6000, 251000, 32'h0));
    send_fix(origin_fix);
    send_fix(make_fix(32'h4000_0000, 32'h0, 0, 32'h7FFF_FFFF));
    send_fix(make_fix(32'hC000_0000, 32'h8000_0000, -10000000, 32'h8000_0000));
    send_fix(make_fix(32'h0, 32'h7FFF_FFFF, 100000000, 32'h4000_0000));
    send_fix(make_fix(32'h7FFF_FFFF, 32'h4000_0000, -1, 32'h3FFF_FFFF));
    send_fix(make_fix(32'h8000_0000, 32'hC000_0000, 32'h07FF_FFFF, 32'hFFFF_FFFF));
    send_fix(make_fix(32'h5000_0000, 32'h2000_0000, 32'h0800_0000, 32'h1234_5678));
    send_fix(make_fix(32'hFFFF_FFFF, 32'h0000_0001, 1, 32'h0000_0001));
    send_fix(make_fix(32'h2000_0000, 32'hE000_0000, 8848000, 32'hC000_0000));
    wait_drained();
  endtask

  // register writes after the latch must leave the origin alone
  task automatic test_writes_after_latch();
    write_reg(CFG_ORIGIN_FROM_FIRST_FIX, 32'd1);
    write_reg(CFG_HEADING_FROM_NORTH, 32'd0);
    write_reg(CFG_PRESET_ORIGIN_LAT, 32'hC000_0000);
    write_reg(CFG_PRESET_ORIGIN_LON, 32'h8000_0000);
    write_reg(CFG_PRESET_ORIGIN_ALT, 32'h05F5_E100);
    send_fix(origin_fix);
    send_fix(make_fix(32'h1FFF_0000, 32'h1555_0000, 240000, 32'h4000_0000));
    send_fix(make_fix(32'h4000_0000, 32'h7FFF_FFFF, 100000000, 32'h0));
    wait_drained();
    write_reg(CFG_PRESET_ORIGIN_LAT, 32'h4000_0000);
    write_reg(CFG_PRESET_ORIGIN_LON, 32'h7FFF_FFFF);
    write_reg(CFG_PRESET_ORIGIN_ALT, 32'hFF67_6980);
    write_reg(CFG_HEADING_FROM_NORTH, 32'd1);
    send_fix(make_fix(32'h0, 32'h0, 0, 32'h0));
    wait_drained();
  endtask

  // long receiver hold-off so the block backs up onto its input
  task automatic test_back_pressure();
    hold_req = 1'b1;
    repeat (12) send_fix(random_fix());
    wait_drained();
  endtask

  task automatic test_random_fixes();
    repeat (200) send_fix(random_fix());
    wait_drained();
    write_reg(CFG_HEADING_FROM_NORTH, 32'd0);
    repeat (150) send_fix(random_fix());
    wait_drained();
    write_reg(CFG_HEADING_FROM_NORTH, 32'd1);
    no_idle = 1'b1;
    repeat (70) send_fix(random_fix());
    wait_drained();
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_ORIGIN_FROM_FIRST_FIX;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    fix_lat_i <= '0;
    fix_lon_i <= '0;
    fix_alt_i <= '0;
    fix_heading_i <= '0;
    latch_from_fix = 1'b1;
    yaw_from_north = 1'b1;
    preset_lat = '0;
    preset_lon = '0;
    preset_alt = '0;
    origin_set = 1'b0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    fixes_sent = 0;
    results_checked = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_preset_origin();
    test_writes_after_latch();
    test_back_pressure();
    test_random_fixes();
    repeat (500) @(posedge clk_i);
    if (expected_enu.size() != 0) mismatches++;
    $display("covered %0d fixes against a preset origin, heading modes and back-pressure;",
             fixes_sent);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
